// ===== hw/rtl/pmd_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pmd_pkg
// Shared constants and types of the PID motor drive: fixed-point formats,
// register indexes and the command and status bundles between the
// controller and the datapath.
// ============================================================================
package pmd_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int FRAC_BITS   = 16;
   localparam int PERIOD_BITS = 16;
   localparam int FLOOR_BITS  = 31;
   localparam int LIMIT_BITS  = 15;
   localparam int CSR_IDX_W   = 3;

   localparam int INTEG_BOUND = 100;
   localparam int INTEG_W     = $clog2(INTEG_BOUND + 1) + FRAC_BITS + 1;
   localparam int DIFF_W      = DATA_WIDTH + 1;
   localparam int MUL_B_W     = DATA_WIDTH + 1;
   localparam int PROD_W      = DATA_WIDTH + MUL_B_W;
   localparam int TERM_W      = 2 * DATA_WIDTH - FRAC_BITS;
   localparam int ACC_W       = TERM_W + 2;
   localparam int DIV_W       = DATA_WIDTH + PERIOD_BITS;
   localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
   localparam int DUTY_W      = LIMIT_BITS;

   localparam logic [LIMIT_BITS-1:0] DRIVE_LIMIT_RST = LIMIT_BITS'(255);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P         = 3'd0,
      CSR_GAIN_I         = 3'd1,
      CSR_GAIN_D         = 3'd2,
      CSR_FRICTION_FLOOR = 3'd3,
      CSR_DRIVE_LIMIT    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_ERR_PERIOD = 2'd0,
      MUL_GAIN_P     = 2'd1,
      MUL_GAIN_I     = 2'd2,
      MUL_GAIN_D     = 2'd3
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_LOAD = 2'd1,
      ACC_ADD  = 2'd2
   } acc_op_type;

   typedef struct packed {
      logic        capture;
      logic        div_start;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        integ_update;
      acc_op_type  acc_op;
      logic        deriv_load;
      logic        finish;
   } pmd_cmd_type;

   typedef struct packed {
      logic div_done;
   } pmd_status_type;

endpackage

// ===== hw/rtl/pid_motor_drive.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pid_motor_drive
// Position PID controller with integral clamp, derivative by division,
// drive saturation and static-friction compensation for a PWM bridge.
// ============================================================================
// Usage:
//   req_* carries one item (measured position, target, period); it is taken
//   at a clock edge with req_valid high and req_stall low. rsp_* returns one
//   result per item (drive, PWM duty, direction) under the same rule.
//   csr_* writes gains, friction floor and drive limit by index; csr_ready
//   is always high. Write only while no item is in flight.
//   One item is in flight at a time: a new item is taken only once the last
//   result is written into the output register. The 48-step derivative
//   divider sets the pace, with the three products of the shared multiplier
//   overlapped behind it.
//   A finished result sits in the output register; while rsp_stall holds it
//   the next item is still taken and computed, then waits until the output
//   register frees up.
//   Reset (synchronous) clears the integral and previous error, sets gains
//   and friction floor to zero and the drive limit to 255, and empties the
//   output register.
// ============================================================================
module pid_motor_drive
   import pmd_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [DATA_WIDTH-1:0]   req_measured_position,
   input  logic signed [DATA_WIDTH-1:0]   req_target_position,
   input  logic        [PERIOD_BITS-1:0]  req_period,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [DATA_WIDTH-1:0]   rsp_drive_value,
   output logic        [DUTY_W-1:0]       rsp_pwm_duty,
   output logic                           rsp_forward,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic        [CSR_IDX_W-1:0]    csr_index,
   input  logic        [DATA_WIDTH-1:0]   csr_data
);

   pmd_cmd_type    cmd;
   pmd_status_type status;

   assign csr_ready = 1'b1;

   pmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   pmd_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_measured_position (req_measured_position),
      .req_target_position   (req_target_position),
      .req_period            (req_period),
      .csr_write             (csr_valid && csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .rsp_drive_value       (rsp_drive_value),
      .rsp_pwm_duty          (rsp_pwm_duty),
      .rsp_forward           (rsp_forward)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item taken while another is in flight");

   a_forward_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_forward) |-> (rsp_drive_value > 0))
      else $error("forward set without a positive drive");

   a_zero_drive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_drive_value == 0) |-> (rsp_pwm_duty == 0 && !rsp_forward))
      else $error("zero drive with nonzero duty or forward");

   a_result_after_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_stall == 1'b0)
      else $error("result raised while the sequencer is busy");

endmodule

// ===== hw/rtl/pmd_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pmd_ctrl
// Sequencer of the PID motor drive: steps one item through error capture,
// integral update, the shared multiplier, the divider wait and the output.
// ============================================================================
module pmd_ctrl
   import pmd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic           rsp_stall,
   output logic           rsp_valid,
   output pmd_cmd_type    cmd,
   input  pmd_status_type status
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_ERRP  = 9'b000000010,
      ST_INTEG = 9'b000000100,
      ST_PTERM = 9'b000001000,
      ST_ITERM = 9'b000010000,
      ST_DWAIT = 9'b000100000,
      ST_DMUL  = 9'b001000000,
      ST_DTERM = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in         = state_ff;
      cmd.capture      = 1'b0;
      cmd.div_start    = 1'b0;
      cmd.mul_en       = 1'b0;
      cmd.mul_sel      = MUL_ERR_PERIOD;
      cmd.integ_update = 1'b0;
      cmd.acc_op       = ACC_HOLD;
      cmd.deriv_load   = 1'b0;
      cmd.finish       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_ERRP;
            end
         end
         ST_ERRP: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_ERR_PERIOD;
            cmd.div_start = 1'b1;
            state_in      = ST_INTEG;
         end
         ST_INTEG: begin
            cmd.integ_update = 1'b1;
            cmd.mul_en       = 1'b1;
            cmd.mul_sel      = MUL_GAIN_P;
            state_in         = ST_PTERM;
         end
         ST_PTERM: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_GAIN_I;
            state_in    = ST_ITERM;
         end
         ST_ITERM: begin
            cmd.acc_op = ACC_ADD;
            state_in   = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (status.div_done) begin
               cmd.deriv_load = 1'b1;
               state_in       = ST_DMUL;
            end
         end
         ST_DMUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_GAIN_D;
            state_in    = ST_DTERM;
         end
         ST_DTERM: begin
            cmd.acc_op = ACC_ADD;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/pmd_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pmd_datapath
// Arithmetic of the PID motor drive: configuration registers, error and
// integral registers, a shared signed multiplier, a radix-2 restoring
// divider for the derivative, the term accumulator and the output stage.
// ============================================================================
module pmd_datapath
   import pmd_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  pmd_cmd_type                    cmd,
   output pmd_status_type                 status,
   input  logic signed [DATA_WIDTH-1:0]   req_measured_position,
   input  logic signed [DATA_WIDTH-1:0]   req_target_position,
   input  logic        [PERIOD_BITS-1:0]  req_period,
   input  logic                           csr_write,
   input  logic        [CSR_IDX_W-1:0]    csr_index,
   input  logic        [DATA_WIDTH-1:0]   csr_data,
   output logic signed [DATA_WIDTH-1:0]   rsp_drive_value,
   output logic        [DUTY_W-1:0]       rsp_pwm_duty,
   output logic                           rsp_forward
);

   localparam logic signed [DIFF_W-1:0]  DW_MAX = DIFF_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
   localparam logic signed [DIFF_W-1:0]  DW_MIN = -DW_MAX - DIFF_W'(1);
   localparam logic signed [DIFF_W-1:0]  IBOUND = DIFF_W'(INTEG_BOUND * (64'd1 << FRAC_BITS));
   localparam logic        [DIFF_W-1:0]  CAP_POS = DIFF_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
   localparam logic        [DIFF_W-1:0]  CAP_NEG = DIFF_W'(64'd1 << (DATA_WIDTH - 1));

   // configuration
   logic signed [DATA_WIDTH-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic        [FLOOR_BITS-1:0] floor_ff;
   logic        [LIMIT_BITS-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= '0;
         gain_i_ff <= '0;
         gain_d_ff <= '0;
         floor_ff  <= '0;
         limit_ff  <= DRIVE_LIMIT_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_GAIN_P:         gain_p_ff <= csr_data;
            CSR_GAIN_I:         gain_i_ff <= csr_data;
            CSR_GAIN_D:         gain_d_ff <= csr_data;
            CSR_FRICTION_FLOOR: floor_ff  <= csr_data[FLOOR_BITS-1:0];
            CSR_DRIVE_LIMIT:    limit_ff  <= csr_data[LIMIT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // error capture
   logic signed [DIFF_W-1:0]      err_diff;
   logic signed [DATA_WIDTH-1:0]  err_in, err_ff, prev_err_ff;
   logic        [PERIOD_BITS-1:0] period_ff;

   assign err_diff = DIFF_W'(req_target_position) - DIFF_W'(req_measured_position);

   always_comb begin
      if (err_diff > DW_MAX) begin
         err_in = DW_MAX[DATA_WIDTH-1:0];
      end else if (err_diff < DW_MIN) begin
         err_in = DW_MIN[DATA_WIDTH-1:0];
      end else begin
         err_in = err_diff[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         err_ff    <= err_in;
         period_ff <= req_period;
      end
   end

   // shared multiplier
   logic signed [DATA_WIDTH-1:0] mul_a;
   logic signed [MUL_B_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [INTEG_W-1:0]    integ_ff;
   logic signed [DATA_WIDTH-1:0] deriv_ff;

   always_comb begin
      case (cmd.mul_sel)
         MUL_ERR_PERIOD: begin
            mul_a = err_ff;
            mul_b = MUL_B_W'({1'b0, period_ff});
         end
         MUL_GAIN_P: begin
            mul_a = gain_p_ff;
            mul_b = MUL_B_W'(err_ff);
         end
         MUL_GAIN_I: begin
            mul_a = gain_i_ff;
            mul_b = MUL_B_W'(integ_ff);
         end
         MUL_GAIN_D: begin
            mul_a = gain_d_ff;
            mul_b = MUL_B_W'(deriv_ff);
         end
         default: begin
            mul_a = err_ff;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // integral with clamp
   logic signed [DATA_WIDTH-1:0] integ_inc;
   logic signed [DIFF_W-1:0]     integ_sum;
   logic signed [INTEG_W-1:0]    integ_in;

   assign integ_inc = prod_ff[PERIOD_BITS +: DATA_WIDTH];
   assign integ_sum = DIFF_W'(integ_ff) + DIFF_W'(integ_inc);

   always_comb begin
      if (integ_sum > IBOUND) begin
         integ_in = IBOUND[INTEG_W-1:0];
      end else if (integ_sum < -IBOUND) begin
         integ_in = INTEG_W'(-IBOUND);
      end else begin
         integ_in = integ_sum[INTEG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         prev_err_ff <= '0;
      end else begin
         if (cmd.integ_update) begin
            integ_ff <= integ_in;
         end
         if (cmd.div_start) begin
            prev_err_ff <= err_ff;
         end
      end
   end

   // derivative divider: (|diff| << PERIOD_BITS) / period, one bit a cycle
   logic signed [DIFF_W-1:0]      dd_diff;
   logic        [DIFF_W-1:0]      dd_mag;
   logic        [DIV_W-1:0]       div_dvd_ff, div_dvd_in;
   logic        [PERIOD_BITS-1:0] div_rem_ff, div_rem_in;
   logic        [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                          dd_neg_ff, dd_zero_ff;
   logic        [PERIOD_BITS:0]   div_trial;
   logic                          div_ge;

   assign dd_diff   = DIFF_W'(err_ff) - DIFF_W'(prev_err_ff);
   assign dd_mag    = dd_diff[DIFF_W-1] ? DIFF_W'(-dd_diff) : dd_diff;
   assign div_trial = {div_rem_ff, div_dvd_ff[DIV_W-1]};
   assign div_ge    = (div_trial >= {1'b0, period_ff});
   assign status.div_done = (div_cnt_ff == '0);

   always_comb begin
      div_dvd_in = div_dvd_ff;
      div_rem_in = div_rem_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.div_start) begin
         div_dvd_in = {dd_mag[DATA_WIDTH-1:0], {PERIOD_BITS{1'b0}}};
         div_rem_in = '0;
         div_cnt_in = DIV_CNT_W'(DIV_W);
      end else if (div_cnt_ff != '0) begin
         div_dvd_in = {div_dvd_ff[DIV_W-2:0], div_ge};
         div_rem_in = div_ge ? PERIOD_BITS'(div_trial - {1'b0, period_ff})
                             : div_trial[PERIOD_BITS-1:0];
         div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else begin
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_dvd_ff <= div_dvd_in;
      div_rem_ff <= div_rem_in;
      if (cmd.div_start) begin
         dd_neg_ff  <= dd_diff[DIFF_W-1];
         dd_zero_ff <= (dd_diff == '0);
      end
   end

   logic [DIFF_W-1:0]            deriv_cap, deriv_mag;
   logic signed [DIFF_W-1:0]     deriv_wide;
   logic signed [DATA_WIDTH-1:0] deriv_in;

   assign deriv_cap = dd_neg_ff ? CAP_NEG : CAP_POS;

   always_comb begin
      if (period_ff == '0 || div_dvd_ff > DIV_W'(deriv_cap)) begin
         deriv_mag = deriv_cap;
      end else begin
         deriv_mag = div_dvd_ff[DIFF_W-1:0];
      end
      deriv_wide = dd_neg_ff ? DIFF_W'(-deriv_mag) : DIFF_W'(deriv_mag);
      deriv_in   = dd_zero_ff ? '0 : deriv_wide[DATA_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.deriv_load) begin
         deriv_ff <= deriv_in;
      end
   end

   // term accumulator
   logic signed [TERM_W-1:0] term;
   logic signed [ACC_W-1:0]  acc_ff;

   assign term = prod_ff[FRAC_BITS +: TERM_W];

   always_ff @(posedge clock) begin
      case (cmd.acc_op)
         ACC_LOAD: acc_ff <= ACC_W'(term);
         ACC_ADD:  acc_ff <= acc_ff + ACC_W'(term);
         default: begin
         end
      endcase
   end

   // limit, friction compensation, output register
   logic signed [ACC_W-1:0]      dlim;
   logic signed [DATA_WIDTH-1:0] clamped, fl, drive;
   logic        [DATA_WIDTH-1:0] drive_mag;
   logic        [DUTY_W-1:0]     duty;

   assign dlim = ACC_W'({limit_ff, {FRAC_BITS{1'b0}}});
   assign fl   = DATA_WIDTH'({1'b0, floor_ff});

   always_comb begin
      if (acc_ff > dlim) begin
         clamped = dlim[DATA_WIDTH-1:0];
      end else if (acc_ff < -dlim) begin
         clamped = DATA_WIDTH'(-dlim);
      end else begin
         clamped = acc_ff[DATA_WIDTH-1:0];
      end
      drive = clamped;
      if (clamped > 0 && clamped < fl) begin
         drive = fl;
      end else if (clamped < 0 && clamped > -fl) begin
         drive = -fl;
      end
      drive_mag = drive[DATA_WIDTH-1] ? DATA_WIDTH'(-drive) : DATA_WIDTH'(drive);
      if (drive_mag[DATA_WIDTH-1:FRAC_BITS + DUTY_W] != '0) begin
         duty = '1;
      end else begin
         duty = drive_mag[FRAC_BITS +: DUTY_W];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_drive_value <= drive;
         rsp_pwm_duty    <= duty;
         rsp_forward     <= (drive > 0);
      end
   end

endmodule

// ===== bench/pid_motor_drive_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pid_motor_drive_tb
// Self-checking bench for the PID motor drive. Items are sent in random
// bursts while the result side stalls on its own pattern. A local fixed-point
// model of the controller (error, clamped integral, divided derivative,
// drive limit, friction floor) predicts every result, and each result is
// compared field by field in order. Directed cases cover the field extremes,
// zero period, integral clamping, floor above limit and zero limit. Random
// phases then send tracking items under many register settings.
// ============================================================================
module pid_motor_drive_tb;
   import pmd_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int IDLE_CYCLES = 60;
   localparam int PRINT_CAP   = 40;

   localparam logic signed [DATA_WIDTH-1:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_WIDTH-1:0] POS_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_WIDTH-1:0] ONE     = 32'sh0001_0000;

   typedef struct {
      logic signed [DATA_WIDTH-1:0] drive;
      logic        [DUTY_W-1:0]     duty;
      logic                         fwd;
   } drive_out_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [DATA_WIDTH-1:0]  req_measured_position = '0;
   logic signed [DATA_WIDTH-1:0]  req_target_position = '0;
   logic        [PERIOD_BITS-1:0] req_period = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [DATA_WIDTH-1:0]  rsp_drive_value;
   logic        [DUTY_W-1:0]      rsp_pwm_duty;
   logic                          rsp_forward;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic        [CSR_IDX_W-1:0]   csr_index = '0;
   logic        [DATA_WIDTH-1:0]  csr_data = '0;

   // controller copy
   logic signed [DATA_WIDTH-1:0]  gain_p_q   = '0;
   logic signed [DATA_WIDTH-1:0]  gain_i_q   = '0;
   logic signed [DATA_WIDTH-1:0]  gain_d_q   = '0;
   logic        [FLOOR_BITS-1:0]  floor_q    = '0;
   logic        [LIMIT_BITS-1:0]  limit_q    = DRIVE_LIMIT_RST;
   logic signed [DATA_WIDTH-1:0]  integ_q    = '0;
   logic signed [DATA_WIDTH-1:0]  prev_err_q = '0;

   drive_out_type pending_drives[$];

   int mismatches     = 0;
   int items_sent     = 0;
   int results_seen   = 0;
   int reg_writes     = 0;
   int settings_used  = 0;
   int burst_left     = 0;
   int stall_run      = 0;
   int quiet_cycles   = 0;
   logic signed [DATA_WIDTH-1:0] track_pos = '0;

   pid_motor_drive u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_measured_position (req_measured_position),
      .req_target_position   (req_target_position),
      .req_period            (req_period),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_drive_value       (rsp_drive_value),
      .rsp_pwm_duty          (rsp_pwm_duty),
      .rsp_forward           (rsp_forward),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report(input string msg);
      if (mismatches < PRINT_CAP) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      mismatches++;
   endtask

   function automatic drive_out_type compute_drive(input logic signed [DATA_WIDTH-1:0] meas,
                                                   input logic signed [DATA_WIDTH-1:0] targ,
                                                   input logic [PERIOD_BITS-1:0] per);
      longint m, t, p, err, integ, ibound, diff, dmag, cap, q, r, v, deriv;
      longint kp, ki, kd, drv, dlim, fl, amag, duty;
      drive_out_type o;
      m = meas;
      t = targ;
      p = per;
      kp = gain_p_q;
      ki = gain_i_q;
      kd = gain_d_q;
      dlim = limit_q;
      dlim = dlim <<< FRAC_BITS;
      fl = floor_q;
      ibound = longint'(INTEG_BOUND) <<< FRAC_BITS;

      err = t - m;
      if (err > longint'(POS_MAX)) err = POS_MAX;
      if (err < longint'(POS_MIN)) err = POS_MIN;

      integ = integ_q;
      integ = integ + ((err * p) >>> PERIOD_BITS);
      if (integ > ibound) integ = ibound;
      if (integ < -ibound) integ = -ibound;

      diff = err - longint'(prev_err_q);
      if (diff == 0) begin
         deriv = 0;
      end else begin
         dmag = (diff < 0) ? -diff : diff;
         cap = (diff < 0) ? 64'sh8000_0000 : 64'sh7FFF_FFFF;
         if (p == 0) begin
            v = cap;
         end else begin
            q = dmag / p;
            r = dmag % p;
            if (q > 32767) begin
               v = cap;
            end else begin
               v = (q <<< PERIOD_BITS) + ((r <<< PERIOD_BITS) / p);
               if (v > cap) v = cap;
            end
         end
         deriv = (diff < 0) ? -v : v;
      end

      drv = ((kp * err) >>> FRAC_BITS) + ((ki * integ) >>> FRAC_BITS)
          + ((kd * deriv) >>> FRAC_BITS);
      if (drv > dlim) drv = dlim;
      if (drv < -dlim) drv = -dlim;
      if (drv > 0 && drv < fl) drv = fl;
      if (drv < 0 && drv > -fl) drv = -fl;

      integ_q = integ[DATA_WIDTH-1:0];
      prev_err_q = err[DATA_WIDTH-1:0];

      amag = (drv < 0) ? -drv : drv;
      duty = amag >>> FRAC_BITS;
      if (duty > 32767) duty = 32767;
      o.drive = drv[DATA_WIDTH-1:0];
      o.duty = duty[DUTY_W-1:0];
      o.fwd = (drv > 0);
      return o;
   endfunction

   task automatic send_item(input logic signed [DATA_WIDTH-1:0] meas,
                            input logic signed [DATA_WIDTH-1:0] targ,
                            input logic [PERIOD_BITS-1:0] per);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         case ($urandom_range(0, 3))
            0: gap = 0;
            1: gap = $urandom_range(40, 80);
            default: gap = $urandom_range(1, 20);
         endcase
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_measured_position <= meas;
      req_target_position <= targ;
      req_period <= per;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_drives.push_back(compute_drive(meas, targ, per));
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_drives.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      case (idx)
         CSR_GAIN_P:         gain_p_q = value;
         CSR_GAIN_I:         gain_i_q = value;
         CSR_GAIN_D:         gain_d_q = value;
         CSR_FRICTION_FLOOR: floor_q = value[FLOOR_BITS-1:0];
         CSR_DRIVE_LIMIT:    limit_q = value[LIMIT_BITS-1:0];
         default: ;
      endcase
      reg_writes++;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [DATA_WIDTH-1:0] kp, input logic [DATA_WIDTH-1:0] ki,
                                input logic [DATA_WIDTH-1:0] kd,
                                input logic [DATA_WIDTH-1:0] floor_val,
                                input logic [DATA_WIDTH-1:0] limit_val);
      wait_idle();
      write_reg(CSR_GAIN_P, kp);
      write_reg(CSR_GAIN_I, ki);
      write_reg(CSR_GAIN_D, kd);
      write_reg(CSR_FRICTION_FLOOR, floor_val);
      write_reg(CSR_DRIVE_LIMIT, limit_val);
      settings_used++;
   endtask

   function automatic logic [DATA_WIDTH-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return POS_MIN;
         1: return POS_MAX;
         2: return $urandom;
         default: return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
      endcase
   endfunction

   function automatic logic [DATA_WIDTH-1:0] pick_floor();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 32'h7FFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(0, 32'h4_0000);
      endcase
   endfunction

   function automatic logic [DATA_WIDTH-1:0] pick_limit();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 1;
         2: return 32767;
         3: return $urandom;
         default: return $urandom_range(1, 1000);
      endcase
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] pick_extreme();
      case ($urandom_range(0, 3))
         0: return POS_MIN;
         1: return POS_MAX;
         2: return 0;
         default: return -1;
      endcase
   endfunction

   // mostly a target that wanders with the axis close behind it
   task automatic send_random_item();
      logic signed [DATA_WIDTH-1:0] meas, targ;
      logic [PERIOD_BITS-1:0] per;
      int kind, ofs;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         track_pos = track_pos + int'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
         ofs = $urandom_range(0, 32'h10_0000);
         targ = track_pos;
         meas = targ + ofs - 32'h8_0000;
      end else if (kind < 9) begin
         targ = $urandom;
         meas = $urandom;
      end else begin
         targ = pick_extreme();
         meas = pick_extreme();
      end
      case ($urandom_range(0, 7))
         0: per = 0;
         1: per = 16'hFFFF;
         2: per = $urandom;
         default: per = $urandom_range(16, 4096);
      endcase
      send_item(meas, targ, per);
   endtask

   task automatic test_after_reset();
      send_item(0, 0, 16'd100);
      send_item(POS_MIN, POS_MAX, 16'hFFFF);
      send_item(ONE, -ONE, 0);
   endtask

   task automatic test_saturation_and_clamp();
      load_settings(ONE, 32'h0000_8000, 32'h0000_0100, 32'h0000_8000, 255);
      send_item(POS_MIN, POS_MAX, 16'hFFFF);
      send_item(POS_MAX, POS_MIN, 16'hFFFF);
      send_item(0, 0, 0);
      send_item(0, 0, 0);
      send_item(5 * ONE, 0, 0);
      send_item(0, 60 * ONE, 16'hFFFF);
      send_item(0, 60 * ONE, 16'hFFFF);
      send_item(0, 60 * ONE, 16'hFFFF);
      send_item(0, 60 * ONE, 16'hFFFF);
   endtask

   task automatic test_friction_floor();
      load_settings(ONE, 0, 0, 32'h0000_8000, 255);
      send_item(0, 1, 16'd1);
      send_item(1, 0, 16'd1);
      send_item(0, 0, 16'd7);
      // floor well above the limit
      load_settings(ONE, 0, 0, 32'h7FFF_FFFF, 1);
      send_item(0, 3 * ONE, 16'd100);
      send_item(3 * ONE, 0, 16'd100);
      load_settings(ONE, 0, 0, 32'h7FFF_FFFF, 0);
      send_item(0, 3 * ONE, 16'd100);
   endtask

   task automatic test_gain_extremes();
      load_settings(POS_MIN, POS_MAX, POS_MIN, 0, 32767);
      send_item(POS_MIN, POS_MAX, 16'd1);
      send_item(POS_MAX, POS_MIN, 0);
      send_item(32'sd123456, -32'sd98765, 16'hFFFF);
   endtask

   task automatic test_random_tracking();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: load_settings(POS_MAX, POS_MAX, POS_MAX, 32'h7FFF_FFFF, 32767);
            1: load_settings(POS_MIN, POS_MIN, POS_MIN, 0, 1);
            default: load_settings(pick_gain(), pick_gain(), pick_gain(), pick_floor(),
                                   pick_limit());
         endcase
         repeat (75) send_random_item();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run == 0) begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_run <= $urandom_range(1, 40);
      end else begin
         stall_run <= stall_run - 1;
      end
   end

   always @(posedge clock) begin
      drive_out_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         results_seen++;
         if (pending_drives.size() == 0) begin
            report($sformatf("result with nothing outstanding, drive %h", rsp_drive_value));
         end else begin
            want = pending_drives.pop_front();
            if (rsp_drive_value !== want.drive)
               report($sformatf("drive_value %h, want %h", rsp_drive_value, want.drive));
            if (rsp_pwm_duty !== want.duty)
               report($sformatf("pwm_duty %0d, want %0d", rsp_pwm_duty, want.duty));
            if (rsp_forward !== want.fwd)
               report($sformatf("forward %b, want %b", rsp_forward, want.fwd));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)
          || (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no handshake for %0d cycles", QUIET_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_after_reset();
      test_saturation_and_clamp();
      test_friction_floor();
      test_gain_extremes();
      test_random_tracking();
      wait_idle();
      if (pending_drives.size() != 0)
         report($sformatf("%0d results never arrived", pending_drives.size()));
      $display("%0d items sent, %0d results checked, %0d mismatches", items_sent,
               results_seen, mismatches);
      $display("%0d register writes over %0d settings, incl. zero period and limit cases",
               reg_writes, settings_used);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
